/* src/cbm_pkg.sv */
// cbm_pkg: types, decode constants and remap functions of the cartridge bank mapper
// used by cartridge_bank_mapper_irq_top; depends on nothing else
`default_nettype none

package cbm_pkg;

   // request operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // register decode
   localparam logic [15:0] ADDR_MASK   = 16'hF007;
   localparam logic [15:0] ADDR_JUMPER = 16'h5000;
   localparam logic [15:0] ADDR_MODE   = 16'hD000;
   localparam logic [15:0] ADDR_MIRROR = 16'hD001;
   localparam logic [3:0]  PAGE_PRG    = 4'h8;
   localparam logic [3:0]  PAGE_CHR_LO = 4'h9;
   localparam logic [3:0]  PAGE_CHR_HI = 4'hA;
   localparam logic [3:0]  PAGE_IRQ    = 4'hC;

   // irq register offsets within the 0xC00x page
   localparam logic [1:0] IRQ_RELOAD  = 2'd0;
   localparam logic [1:0] IRQ_LOAD    = 2'd1;
   localparam logic [1:0] IRQ_DISABLE = 2'd2;
   localparam logic [1:0] IRQ_ENABLE  = 2'd3;

   typedef logic [3:0][7:0]  prg_regs_type;
   typedef logic [7:0][7:0]  chr_regs_type;
   typedef logic [3:0][8:0]  prg_map_type;
   typedef logic [7:0][18:0] chr_map_type;

   // program slot map from the bank registers, mode 0 keeps the old map
   function automatic prg_map_type prg_remap(input prg_regs_type regs,
                                             input logic [1:0] sel,
                                             input prg_map_type cur);
      prg_map_type m;
      m = cur;
      case (sel)
         2'd1: begin
            m[0] = {regs[0], 1'b0};
            m[1] = {regs[0], 1'b1};
            m[2] = {regs[2], 1'b0};
            m[3] = {regs[2], 1'b1};
         end
         2'd2, 2'd3: begin
            for (int i = 0; i < 4; i++) begin
               m[i] = {1'b0, regs[i]};
            end
         end
         default: m = cur;
      endcase
      return m;
   endfunction

   // pattern slot map: 8KB, 4KB, 2KB or 1KB grouping
   function automatic chr_map_type chr_remap(input chr_regs_type lo,
                                             input chr_regs_type hi,
                                             input logic [1:0] sel);
      chr_map_type m;
      logic [2:0]  keep;
      logic [2:0]  slot;
      logic [2:0]  base;
      logic [15:0] v;
      logic [18:0] vs;
      case (sel)
         2'd0:    keep = 3'b000;
         2'd1:    keep = 3'b100;
         2'd2:    keep = 3'b110;
         default: keep = 3'b111;
      endcase
      for (int i = 0; i < 8; i++) begin
         slot = 3'(i);
         base = slot & keep;
         v    = {hi[base], lo[base]};
         case (sel)
            2'd0:    vs = {v, 3'b000};
            2'd1:    vs = {1'b0, v, 2'b00};
            2'd2:    vs = {2'b00, v, 1'b0};
            default: vs = {3'b000, v};
         endcase
         m[i] = vs + {16'd0, slot - base};
      end
      return m;
   endfunction

endpackage

`default_nettype wire

/* src/cartridge_bank_mapper_irq_top.sv */
// cartridge_bank_mapper_irq_top: bank mapper with scanline irq counter, single module
// depends on cbm_pkg for decode constants, map types and remap functions
`default_nettype none

// usage
// - request channel (req_*): one cpu register write, cpu read or scanline tick per
//   request, with the cpu and ppu addresses to look up
// - response channel (rsp_*): exactly one response per request, in order, carrying
//   read data and hit, irq line, mirroring mode and the mapped program and pattern banks,
//   all as they stand after that request has taken effect
// - csr port: csr_wr_en with csr_wr_data loads the jumper byte returned on reads of
//   0x5000; write it only while no request is in flight
// - path: a request is captured in the input register, decoded and applied to the
//   mapper state on its way into the response register, where it is held as the
//   valid response until it is taken
// - throughput: one request per cycle while responses are taken, set by the single
//   decode pass between the input and response registers
// - stalls: while rsp_ready is low the response holds; the input register can still
//   take one request, after which req_ready drops until the response is taken
// - reset: synchronous, clears both pipeline stages, all bank registers, maps, irq
//   state, mirroring and the jumper byte
module cartridge_bank_mapper_irq_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_cpu_addr,
   input  wire logic [7:0]  req_data,
   input  wire logic [12:0] req_ppu_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_read_hit,
   output logic             rsp_irq_line,
   output logic [1:0]       rsp_mirror_mode,
   output logic [8:0]       rsp_prg_bank,
   output logic [18:0]      rsp_chr_bank,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);
   import cbm_pkg::*;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff;
   logic [15:0] s1_cpu_ff;
   logic [7:0]  s1_data_ff;
   logic [12:0] s1_ppu_ff;

   // mapper state
   logic [7:0]   jumper_ff;
   prg_regs_type prg_regs_ff, prg_regs_in;
   chr_regs_type chr_lo_ff, chr_lo_in;
   chr_regs_type chr_hi_ff, chr_hi_in;
   logic [7:0]   mode_ff, mode_in;
   prg_map_type  prg_map_ff, prg_map_in;
   chr_map_type  chr_map_ff, chr_map_in;
   logic [7:0]   irq_reload_ff, irq_reload_in;
   logic [7:0]   irq_count_ff, irq_count_in;
   logic         irq_en_ff, irq_en_in;
   logic         irq_pend_ff, irq_pend_in;
   logic [1:0]   mirror_ff, mirror_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_data_ff, rsp_read_data_in;
   logic        rsp_read_hit_ff, rsp_read_hit_in;
   logic [8:0]  rsp_prg_bank_ff, rsp_prg_bank_in;
   logic [18:0] rsp_chr_bank_ff, rsp_chr_bank_in;

   logic        out_free;
   logic        advance;
   logic [15:0] addr_m;
   logic [7:0]  count_dec;

   // request moves from the input register into the response register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || advance;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   assign addr_m    = s1_cpu_ff & ADDR_MASK;
   assign count_dec = irq_count_ff - 8'd1;

   // state update for the request in the input register
   always_comb begin
      prg_regs_in      = prg_regs_ff;
      chr_lo_in        = chr_lo_ff;
      chr_hi_in        = chr_hi_ff;
      mode_in          = mode_ff;
      prg_map_in       = prg_map_ff;
      chr_map_in       = chr_map_ff;
      irq_reload_in    = irq_reload_ff;
      irq_count_in     = irq_count_ff;
      irq_en_in        = irq_en_ff;
      irq_pend_in      = irq_pend_ff;
      mirror_in        = mirror_ff;
      rsp_read_data_in = 8'd0;
      rsp_read_hit_in  = 1'b0;
      if (advance) begin
         unique case (s1_op_ff)
            OP_WRITE: begin
               unique case (addr_m[15:12])
                  PAGE_PRG: begin
                     if (!addr_m[2]) begin
                        prg_regs_in[addr_m[1:0]] = s1_data_ff;
                        prg_map_in = prg_remap(prg_regs_in, mode_ff[1:0], prg_map_ff);
                     end
                  end
                  PAGE_CHR_LO: begin
                     chr_lo_in[addr_m[2:0]] = s1_data_ff;
                     chr_map_in = chr_remap(chr_lo_in, chr_hi_ff, mode_ff[4:3]);
                  end
                  PAGE_CHR_HI: begin
                     chr_hi_in[addr_m[2:0]] = s1_data_ff;
                     chr_map_in = chr_remap(chr_lo_ff, chr_hi_in, mode_ff[4:3]);
                  end
                  PAGE_IRQ: begin
                     unique case (addr_m[1:0])
                        IRQ_RELOAD: irq_reload_in = s1_data_ff;
                        IRQ_LOAD: begin
                           irq_pend_in  = 1'b0;
                           irq_count_in = s1_data_ff;
                        end
                        IRQ_DISABLE: begin
                           irq_pend_in  = 1'b0;
                           irq_en_in    = 1'b0;
                           irq_count_in = irq_reload_ff;
                        end
                        IRQ_ENABLE: irq_en_in = 1'b1;
                        default: irq_en_in = irq_en_ff;
                     endcase
                  end
                  default: begin
                     if (addr_m == ADDR_MODE) begin
                        mode_in = s1_data_ff;
                     end else if (addr_m == ADDR_MIRROR) begin
                        mirror_in = s1_data_ff[1:0];
                     end
                  end
               endcase
            end
            OP_READ: begin
               if (s1_cpu_ff == ADDR_JUMPER) begin
                  rsp_read_data_in = jumper_ff;
                  rsp_read_hit_in  = 1'b1;
               end
            end
            OP_TICK: begin
               // while enabled with a nonzero count: count down, reload and raise the line on reaching zero
               if (irq_en_ff && irq_count_ff != 8'd0) begin
                  if (count_dec == 8'd0) begin
                     irq_pend_in  = 1'b1;
                     irq_count_in = irq_reload_ff;
                  end else begin
                     irq_count_in = count_dec;
                  end
               end
            end
            default: begin
               // unused op code leaves the state alone
               irq_pend_in = irq_pend_ff;
            end
         endcase
      end
   end

   // bank lookups see the maps after this request
   assign rsp_prg_bank_in = s1_cpu_ff[15] ? prg_map_in[s1_cpu_ff[14:13]] : 9'd0;
   assign rsp_chr_bank_in = chr_map_in[s1_ppu_ff[12:10]];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         jumper_ff     <= 8'd0;
         prg_regs_ff   <= '0;
         chr_lo_ff     <= '0;
         chr_hi_ff     <= '0;
         mode_ff       <= 8'd0;
         prg_map_ff    <= '0;
         chr_map_ff    <= '0;
         irq_reload_ff <= 8'd0;
         irq_count_ff  <= 8'd0;
         irq_en_ff     <= 1'b0;
         irq_pend_ff   <= 1'b0;
         mirror_ff     <= 2'd0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            jumper_ff <= csr_wr_data;
         end
         prg_regs_ff   <= prg_regs_in;
         chr_lo_ff     <= chr_lo_in;
         chr_hi_ff     <= chr_hi_in;
         mode_ff       <= mode_in;
         prg_map_ff    <= prg_map_in;
         chr_map_ff    <= chr_map_in;
         irq_reload_ff <= irq_reload_in;
         irq_count_ff  <= irq_count_in;
         irq_en_ff     <= irq_en_in;
         irq_pend_ff   <= irq_pend_in;
         mirror_ff     <= mirror_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff   <= req_op;
         s1_cpu_ff  <= req_cpu_addr;
         s1_data_ff <= req_data;
         s1_ppu_ff  <= req_ppu_addr;
      end
      if (advance) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_read_hit_ff  <= rsp_read_hit_in;
         rsp_prg_bank_ff  <= rsp_prg_bank_in;
         rsp_chr_bank_ff  <= rsp_chr_bank_in;
      end
   end

   // irq line and mirroring are live state, already updated with the response
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_read_hit    = rsp_read_hit_ff;
   assign rsp_irq_line    = irq_pend_ff;
   assign rsp_mirror_mode = mirror_ff;
   assign rsp_prg_bank    = rsp_prg_bank_ff;
   assign rsp_chr_bank    = rsp_chr_bank_ff;

`ifndef SYNTHESIS
   // the irq line only rises on a scanline tick
   a_irq_rise_on_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_pend_ff) |-> $past(advance && s1_op_ff == OP_TICK))
      else $error("irq line rose without a scanline tick");

   // mapper state holds when no request is applied
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mode_ff) && $stable(prg_map_ff) && $stable(chr_map_ff))
      else $error("mapper state changed with no request applied");

   // a miss never returns data
   a_miss_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_read_hit_ff |-> rsp_read_data_ff == 8'd0)
      else $error("read data on a response without a hit");

   // a jumper hit lies below the program window
   a_hit_no_prg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_read_hit_ff |-> rsp_prg_bank_ff == 9'd0)
      else $error("program bank reported on a jumper read");
`endif

endmodule

`default_nettype wire
